// File: hdl/arec_pkg.sv
package arec_pkg;

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BOUNDS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_IDX_FULL = 2'd3;

	// register indexes (word address)
	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_HEADER = 2'd2;

	// register reset values
	localparam logic [20:0] RST_START  = 21'd4096;
	localparam logic [21:0] RST_END    = 22'd1835008;
	localparam logic [7:0]  RST_HEADER = 8'd16;
	localparam logic [21:0] RST_FREE   = 22'd1830912;

	typedef struct packed {
		logic [20:0] region_start;
		logic [21:0] region_end;
		logic [7:0]  header_bytes;
	} cfg_t;

	// controller commands to the datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic exec;
	} ctl_t;

endpackage

// File: hdl/arec_if.sv
interface arec_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [23:0] payload_size;
	logic [5:0]  entry_select;

	modport source (output valid, output cmd, output payload_size, output entry_select,
		input ready);
	modport sink (input valid, input cmd, input payload_size, input entry_select,
		output ready);
endinterface

interface arec_rsp_if #(parameter int ADDR_BITS = 21);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [5:0]           entry_index;
	logic [ADDR_BITS-1:0] entry_address;
	logic [21:0]          entry_size;
	logic                 entry_valid;
	logic [21:0]          free_bytes;
	logic [6:0]           record_count;
	logic                 region_healthy;

	modport source (output valid, output status, output entry_index, output entry_address,
		output entry_size, output entry_valid, output free_bytes, output record_count,
		output region_healthy, input ready);
	modport sink (input valid, input status, input entry_index, input entry_address,
		input entry_size, input entry_valid, input free_bytes, input record_count,
		input region_healthy, output ready);
endinterface

// File: hdl/arec_ram.sv
module arec_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/arec_cfg.sv
module arec_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output arec_pkg::cfg_t    cfg
);
	arec_pkg::cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_start <= arec_pkg::RST_START;
			cfg_q.region_end   <= arec_pkg::RST_END;
			cfg_q.header_bytes <= arec_pkg::RST_HEADER;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				arec_pkg::REG_START:  cfg_q.region_start <= pwdata[20:0];
				arec_pkg::REG_END:    cfg_q.region_end   <= pwdata[21:0];
				arec_pkg::REG_HEADER: cfg_q.header_bytes <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[3:2])
			arec_pkg::REG_START:  prdata = 32'(cfg_q.region_start);
			arec_pkg::REG_END:    prdata = 32'(cfg_q.region_end);
			arec_pkg::REG_HEADER: prdata = 32'(cfg_q.header_bytes);
			default:              prdata = '0;
		endcase
	end
endmodule

// File: hdl/arec_ctrl.sv
module arec_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output arec_pkg::ctl_t ctl
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// commit only when the result register is free or being drained
	assign commit    = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign ctl.load = in_valid && in_ready;
	assign ctl.calc = (state_q == S_CALC);
	assign ctl.exec = commit;

	// sequencer and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: hdl/arec_dp.sv
module arec_dp #(
	parameter int MAX_ENTRIES = 64,
	parameter int ADDR_BITS   = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arec_pkg::cfg_t       cfg,
	input  arec_pkg::ctl_t       ctl,
	input  logic [1:0]           cmd,
	input  logic [23:0]          payload_size,
	input  logic [5:0]           entry_select,
	output logic [1:0]           status,
	output logic [5:0]           entry_index,
	output logic [ADDR_BITS-1:0] entry_address,
	output logic [21:0]          entry_size,
	output logic                 entry_valid,
	output logic [21:0]          free_bytes,
	output logic [6:0]           record_count,
	output logic                 region_healthy
);
	localparam int PW    = ADDR_BITS + 1;
	localparam int W     = (PW > 25 ? PW : 25) + 1;
	localparam int IW    = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int DW    = ADDR_BITS + 22;

	// captured request
	logic [1:0]  cmd_q;
	logic [23:0] pay_q;
	logic [5:0]  sel_q;

	// allocator state
	logic [PW-1:0]    wp_q;
	logic [21:0]      bf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             healthy_q;

	// compare/add stage
	logic         oob_s1;
	logic [24:0]  total_s1;
	logic [W-1:0] sum_s1;

	// result register
	logic [1:0]           status_q;
	logic [5:0]           idx_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [21:0]          size_q;
	logic                 valid_q;
	logic [21:0]          free_q;
	logic [6:0]           count_q;
	logic                 health_q;

	logic [W-1:0]  wp_w, start_w, end_w, span_w, np_w, np_diff_w, cnt_w, max_w, sel_w;
	logic [24:0]   total;
	logic [21:0]   span;
	logic [PW-1:0] rewind_ptr, new_ptr;
	logic [21:0]   bf_alloc;
	logic [W-1:0]  nxt_cnt_w;

	logic [PW-1:0]        nxt_wp;
	logic [21:0]          nxt_bf;
	logic [CNT_W-1:0]     nxt_cnt;
	logic                 nxt_healthy;
	logic [1:0]           res_status;
	logic [5:0]           res_idx;
	logic [ADDR_BITS-1:0] res_addr;
	logic [21:0]          res_size;
	logic                 res_valid;
	logic                 alloc_ok;

	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [IW-1:0] ram_waddr, ram_raddr;

	// common operand views
	assign wp_w      = W'(wp_q);
	assign start_w   = W'(cfg.region_start);
	assign end_w     = W'(cfg.region_end);
	assign cnt_w     = W'(cnt_q);
	assign max_w     = W'(MAX_ENTRIES);
	assign sel_w     = W'(sel_q);
	assign total     = 25'(cfg.header_bytes) + 25'(pay_q);
	assign span_w    = end_w - start_w;
	assign span      = (end_w > start_w) ? span_w[21:0] : '0;
	assign rewind_ptr = start_w[PW-1:0];
	assign new_ptr   = sum_s1[PW-1:0];
	assign np_w      = W'(new_ptr);
	assign np_diff_w = end_w - np_w;
	assign bf_alloc  = (np_w <= end_w) ? np_diff_w[21:0] : '0;

	// index table: address and size per entry
	assign ram_waddr = cnt_q[IW-1:0];
	assign ram_raddr = IW'(sel_q);
	assign ram_wdata = {wp_q[ADDR_BITS-1:0], total_s1[21:0]};

	arec_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ctl.exec && alloc_ok),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.calc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capture request and run the bounds check and end-pointer add
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			pay_q <= payload_size;
			sel_q <= entry_select;
		end
		if (ctl.calc) begin
			oob_s1   <= (wp_w < start_w) || (wp_w >= end_w);
			total_s1 <= total;
			sum_s1   <= wp_w + W'(total);
		end
	end

	// next state and result; table entries below the count are the valid ones
	always_comb begin
		nxt_wp      = wp_q;
		nxt_bf      = bf_q;
		nxt_cnt     = cnt_q;
		nxt_healthy = healthy_q;
		res_status  = arec_pkg::ST_OK;
		res_idx     = '0;
		res_addr    = '0;
		res_size    = '0;
		res_valid   = 1'b0;
		alloc_ok    = 1'b0;
		case (cmd_q)
			arec_pkg::CMD_ALLOC: begin
				res_idx = cnt_w[5:0];
				if (oob_s1) begin
					nxt_wp      = rewind_ptr;
					nxt_bf      = span;
					nxt_healthy = 1'b0;
					res_status  = arec_pkg::ST_BOUNDS;
				end else if (sum_s1 > end_w) begin
					res_status = arec_pkg::ST_FULL;
				end else if (cnt_w >= max_w) begin
					res_status = arec_pkg::ST_IDX_FULL;
				end else begin
					alloc_ok  = 1'b1;
					res_addr  = wp_q[ADDR_BITS-1:0];
					res_size  = total_s1[21:0];
					res_valid = 1'b1;
					nxt_wp    = new_ptr;
					nxt_bf    = bf_alloc;
					nxt_cnt   = cnt_q + CNT_W'(1);
				end
			end
			arec_pkg::CMD_ERASE: begin
				nxt_wp  = rewind_ptr;
				nxt_bf  = span;
				nxt_cnt = '0;
			end
			arec_pkg::CMD_READ: begin
				res_idx = sel_q;
				if (sel_w < cnt_w) begin
					res_addr  = ram_rdata[DW-1:22];
					res_size  = ram_rdata[21:0];
					res_valid = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign nxt_cnt_w = W'(nxt_cnt);

	// allocator state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= PW'(W'(arec_pkg::RST_START));
			bf_q      <= arec_pkg::RST_FREE;
			cnt_q     <= '0;
			healthy_q <= 1'b1;
		end else if (ctl.exec) begin
			wp_q      <= nxt_wp;
			bf_q      <= nxt_bf;
			cnt_q     <= nxt_cnt;
			healthy_q <= nxt_healthy;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= res_status;
			idx_q    <= res_idx;
			addr_q   <= res_addr;
			size_q   <= res_size;
			valid_q  <= res_valid;
			free_q   <= nxt_bf;
			count_q  <= nxt_cnt_w[6:0];
			health_q <= nxt_healthy;
		end
	end

	assign status         = status_q;
	assign entry_index    = idx_q;
	assign entry_address  = addr_q;
	assign entry_size     = size_q;
	assign entry_valid    = valid_q;
	assign free_bytes     = free_q;
	assign record_count   = count_q;
	assign region_healthy = health_q;
endmodule

// File: hdl/append_record_allocator.sv
// Append allocator for variable-size records in a linear region with an index table of
// MAX_ENTRIES entries. Each request (allocate, erase all, read entry) gives one response.
// The operands are captured when the request is accepted. The calc state then registers
// the bounds compare, the end-pointer add and the index table read. The exec state
// commits once the response register is free or being drained: it updates pointer, free
// bytes and count and loads the response register.
// A request is accepted only in the idle state, after the commit of the last one; a
// pending response does not block acceptance, only the commit of the next one. Table
// entries below the record count are the valid ones, so erase needs no clearing pass.
// Region bounds and header length are to be written over the APB port only while no
// request is in flight; the block itself does not enforce this.
module append_record_allocator #(
	parameter int MAX_ENTRIES = 64,
	parameter int ADDR_BITS   = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	arec_req_if.sink    req,
	arec_rsp_if.source  rsp
);
	arec_pkg::cfg_t cfg;
	arec_pkg::ctl_t ctl;

	// configuration registers
	arec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	arec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	// pointer, counters and index table
	arec_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.ctl            (ctl),
		.cmd            (req.cmd),
		.payload_size   (req.payload_size),
		.entry_select   (req.entry_select),
		.status         (rsp.status),
		.entry_index    (rsp.entry_index),
		.entry_address  (rsp.entry_address),
		.entry_size     (rsp.entry_size),
		.entry_valid    (rsp.entry_valid),
		.free_bytes     (rsp.free_bytes),
		.record_count   (rsp.record_count),
		.region_healthy (rsp.region_healthy)
	);
endmodule
